[sv/lfu_page_replacement_macros.svh]
// ----------------------------------------------------------------------------
// LFU page replacement assertion macros
// Shorthand for clocked checks, held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent
`define LFU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lfu_page_replacement check failed");

// Check that a consequent holds in the cycle after its antecedent
`define LFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lfu_page_replacement check failed");

`endif

[sv/lfu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU page replacement package
// Sizes and derived constants shared by the replacement logic.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int PAGE_BITS  = 8;
    localparam int COUNT_BITS = 16;

    localparam int NUM_PAGES = 1 << PAGE_BITS;
    localparam int FRAME_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FILL_W    = $clog2(NUM_FRAMES + 1);
    localparam int FAULT_W   = 32;

    typedef logic [PAGE_BITS-1:0]  t_page;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [FRAME_W-1:0]    t_frame;
    typedef logic [FILL_W-1:0]     t_fill;
    typedef logic [FAULT_W-1:0]    t_fault;

    localparam t_count COUNT_MAX = '1;
    localparam t_fault FAULT_MAX = '1;

    // Saturating increment of a use or history count
    function automatic t_count sat_inc(input t_count v);
        return (v == COUNT_MAX) ? v : v + t_count'(1);
    endfunction

endpackage

[sv/lfu_page_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU page replacement unit
// Tracks resident pages in a small frame set and replaces the least used.
// ----------------------------------------------------------------------------
// Usage:
//   Present a page reference on i_page_number and raise start; the transfer
//   takes place at the rising edge where start is high and busy is low.
//   busy stays low, so a new reference may be given in every cycle.
//   The history table read is issued at the transfer edge; the next cycle
//   does the frame match, the minimum-count victim search and the table
//   write-back, and registers the result. o_done is high for one cycle
//   together with o_was_hit, o_frame_index, o_evicted_valid,
//   o_evicted_page, o_use_count and o_fault_total. Throughput is one
//   reference per cycle; a reference that follows the same page directly
//   takes the history value forwarded from the write-back instead of the
//   stale table read.
//   The receiver cannot stall: each result is shown for exactly one cycle.
//   Reset (synchronous, active low) empties all frames, zeroes the fault
//   count and clears the per-page history valid bits all at once, so there
//   is no clearing pass.
// ----------------------------------------------------------------------------
`include "lfu_page_replacement_macros.svh"

module lfu_page_replacement
    import lfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_page_number,
    output logic        o_done,
    output logic        o_was_hit,
    output logic [1:0]  o_frame_index,
    output logic        o_evicted_valid,
    output logic [7:0]  o_evicted_page,
    output logic [15:0] o_use_count,
    output logic [31:0] o_fault_total
);

    // Frame and counter state
    t_page  r_frame_page  [NUM_FRAMES];
    t_count r_frame_count [NUM_FRAMES];
    t_fill  r_fill;
    t_fault r_fault;

    // History table with per-entry valid bits
    t_count                 r_hist_mem [NUM_PAGES];
    logic [NUM_PAGES-1:0]   r_hist_vld;

    // Stage after the transfer
    logic   r_s1_valid;
    t_page  r_s1_page;
    t_count r_mem_rd;
    logic   r_rd_vld;
    logic   r_fwd;
    t_count r_fwd_val;

    // Result register
    logic        r_done;
    logic        r_was_hit;
    logic [1:0]  r_frame_index;
    logic        r_evicted_valid;
    logic [7:0]  r_evicted_page;
    logic [15:0] r_use_count;
    logic [31:0] r_fault_total;

    logic   accept;
    t_page  in_page;
    t_count hist_old;
    t_count n_hist;
    logic   hit;
    logic   full;
    t_frame slot;
    t_count n_count;
    t_page  n_ev_page;
    t_fault n_fault;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign in_page = t_page'(i_page_number);

    // Pick the history value: forwarded, stored, or cleared
    assign hist_old = r_fwd ? r_fwd_val : (r_rd_vld ? r_mem_rd : '0);
    assign n_hist   = sat_inc(hist_old);

    // Match, victim search and frame update values
    always_comb begin
        t_count best;
        t_frame vic;
        hit  = 1'b0;
        slot = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (!hit && (FILL_W'(i) < r_fill) && (r_frame_page[i] == r_s1_page)) begin
                hit  = 1'b1;
                slot = FRAME_W'(i);
            end
        end
        best = r_frame_count[0];
        vic  = '0;
        for (int i = 1; i < NUM_FRAMES; i++) begin
            if (r_frame_count[i] < best) begin
                best = r_frame_count[i];
                vic  = FRAME_W'(i);
            end
        end
        full      = (r_fill == FILL_W'(NUM_FRAMES));
        n_ev_page = '0;
        if (hit) begin
            n_count = sat_inc(r_frame_count[slot]);
        end else if (!full) begin
            slot    = r_fill[FRAME_W-1:0];
            n_count = t_count'(1);
        end else begin
            slot      = vic;
            n_count   = n_hist;
            n_ev_page = r_frame_page[vic];
        end
        n_fault = (!hit && (r_fault != FAULT_MAX)) ? r_fault + t_fault'(1) : r_fault;
    end

    // Advance the reference into the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_page <= in_page;
            r_rd_vld  <= r_hist_vld[in_page];
            r_fwd     <= r_s1_valid && (r_s1_page == in_page);
            r_fwd_val <= n_hist;
        end
    end

    // Read and write the history table
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_rd <= r_hist_mem[in_page];
        end
        if (r_s1_valid) begin
            r_hist_mem[r_s1_page] <= n_hist;
        end
    end

    // Mark history entries as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (r_s1_valid) begin
            r_hist_vld[r_s1_page] <= 1'b1;
        end
    end

    // Update frames, fill pointer and fault count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_fault <= '0;
        end else if (r_s1_valid) begin
            r_fault <= n_fault;
            if (!hit && !full) begin
                r_fill <= r_fill + t_fill'(1);
            end
        end
        if (r_s1_valid) begin
            r_frame_count[slot] <= n_count;
            if (!hit) begin
                r_frame_page[slot] <= r_s1_page;
            end
        end
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
        if (r_s1_valid) begin
            r_was_hit       <= hit;
            r_frame_index   <= 2'(slot);
            r_evicted_valid <= !hit && full;
            r_evicted_page  <= 8'(n_ev_page);
            r_use_count     <= 16'(n_count);
            r_fault_total   <= 32'(n_fault);
        end
    end

    assign o_done          = r_done;
    assign o_was_hit       = r_was_hit;
    assign o_frame_index   = r_frame_index;
    assign o_evicted_valid = r_evicted_valid;
    assign o_evicted_page  = r_evicted_page;
    assign o_use_count     = r_use_count;
    assign o_fault_total   = r_fault_total;

    // Checks
    `LFU_ASSERT_NEXT(a_transfer_to_stage, accept, r_s1_valid)
    `LFU_ASSERT_NEXT(a_stage_to_result, r_s1_valid, o_done)
    `LFU_ASSERT_SAME(a_evict_on_fault, o_done && o_evicted_valid, !o_was_hit)
    `LFU_ASSERT_SAME(a_fault_counted, o_done && !o_was_hit, o_fault_total != 32'd0)
    `LFU_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FILL_W'(NUM_FRAMES))

endmodule

[tb/lfu_page_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU page replacement checker
// Watches the reference and result channels of the replacement unit, keeps a
// private model of the frames, use counts and per-page history, and compares
// every result field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module lfu_page_checker
    import lfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  i_page_number,
    input  logic        o_done,
    input  logic        o_was_hit,
    input  logic [1:0]  o_frame_index,
    input  logic        o_evicted_valid,
    input  logic [7:0]  o_evicted_page,
    input  logic [15:0] o_use_count,
    input  logic [31:0] o_fault_total,
    output int          o_fail_count,
    output int          o_pending_count
);

    typedef struct {
        logic   was_hit;
        t_frame frame_index;
        logic   evicted_valid;
        t_page  evicted_page;
        t_count use_count;
        t_fault fault_total;
    } t_ref_outcome;

    // Shadow copy of the replacement state
    t_page        frame_page   [NUM_FRAMES];
    t_count       frame_uses   [NUM_FRAMES];
    int           frames_filled = 0;
    t_count       page_history [NUM_PAGES];
    t_fault       faults_seen = '0;

    t_ref_outcome outcome_q[$];
    int           fail_count = 0;

    // Apply one page reference to the shadow state and return its outcome
    function automatic t_ref_outcome apply_reference(input t_page pg);
        t_ref_outcome r;
        t_count       hist;
        int           slot;
        logic         hit;
        hist = page_history[pg];
        if (hist != COUNT_MAX) hist = hist + 1'b1;
        page_history[pg] = hist;

        // Only filled frames may match
        hit  = 1'b0;
        slot = 0;
        for (int i = 0; i < frames_filled; i++) begin
            if (!hit && frame_page[i] == pg) begin
                hit  = 1'b1;
                slot = i;
            end
        end

        r.was_hit       = hit;
        r.evicted_valid = 1'b0;
        r.evicted_page  = '0;
        if (hit) begin
            if (frame_uses[slot] != COUNT_MAX) frame_uses[slot] = frame_uses[slot] + 1'b1;
        end else begin
            if (faults_seen != FAULT_MAX) faults_seen = faults_seen + 1'b1;
            if (frames_filled < NUM_FRAMES) begin
                slot             = frames_filled;
                frame_page[slot] = pg;
                frame_uses[slot] = t_count'(1);
                frames_filled++;
            end else begin
                // Least used frame loses; on a tie the lowest index loses
                slot = 0;
                for (int i = 1; i < NUM_FRAMES; i++) begin
                    if (frame_uses[i] < frame_uses[slot]) slot = i;
                end
                r.evicted_valid  = 1'b1;
                r.evicted_page   = frame_page[slot];
                frame_page[slot] = pg;
                frame_uses[slot] = hist;
            end
        end
        r.frame_index = t_frame'(slot);
        r.use_count   = frame_uses[slot];
        r.fault_total = faults_seen;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Retire results first, then record the reference taken at this edge
    always @(posedge i_clk) begin
        t_ref_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                frame_page[i] = '0;
                frame_uses[i] = '0;
            end
            for (int p = 0; p < NUM_PAGES; p++) page_history[p] = '0;
            frames_filled = 0;
            faults_seen   = '0;
            outcome_q.delete();
        end else begin
            if (o_done) begin
                if (outcome_q.size() == 0) begin
                    $error("result transfer with no reference outstanding");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("was_hit", want.was_hit, o_was_hit);
                    compare_field("frame_index", want.frame_index, o_frame_index);
                    compare_field("evicted_valid", want.evicted_valid, o_evicted_valid);
                    compare_field("evicted_page", want.evicted_page, o_evicted_page);
                    compare_field("use_count", want.use_count, o_use_count);
                    compare_field("fault_total", want.fault_total, o_fault_total);
                end
            end
            if (start && !busy) outcome_q.push_back(apply_reference(t_page'(i_page_number)));
        end
        o_fail_count    <= fail_count;
        o_pending_count <= outcome_q.size();
    end

endmodule

[tb/tb_lfu_page_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU page replacement testbench
// Drives page references in random bursts: a directed opening, a working-set
// random run with noise, and a short hammer phase that builds up use and
// history counts; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lfu_page_replacement;
    import lfu_pkg::*;

    localparam int RANDOM_REFS  = 1700;
    localparam int HAMMER_REFS  = 30;
    localparam int DRAIN_LIMIT  = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_page_number = '0;
    logic        o_done;
    logic        o_was_hit;
    logic [1:0]  o_frame_index;
    logic        o_evicted_valid;
    logic [7:0]  o_evicted_page;
    logic [15:0] o_use_count;
    logic [31:0] o_fault_total;
    int          fail_count;
    int          pending_count;

    lfu_page_replacement DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .o_done          (o_done),
        .o_was_hit       (o_was_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_use_count     (o_use_count),
        .o_fault_total   (o_fault_total)
    );

    lfu_page_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .o_done          (o_done),
        .o_was_hit       (o_was_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_use_count     (o_use_count),
        .o_fault_total   (o_fault_total),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hold a reference on the port until it transfers
    task automatic send_ref(input t_page pg);
        start         <= 1'b1;
        i_page_number <= pg;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start for a number of cycles, with junk on the page port
    task automatic idle_cycles(input int cycles);
        if (cycles > 0) begin
            start         <= 1'b0;
            i_page_number <= t_page'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    initial begin
        t_page opening[];
        t_page hot_pages[4];
        t_page work_set[6];
        t_page last_page;
        t_page pg;
        int    sent;
        int    burst;
        int    pick;
        int    waited;

        opening = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'h10,
                    8'hFF, 8'h10, 8'h10, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00,
                    8'h00, 8'h55, 8'hAA, 8'hFF};
        hot_pages = '{8'h3C, 8'hC3, 8'h0F, 8'hF0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: empty frames, fill order, hits, ties and evictions
        foreach (opening[k]) begin
            send_ref(opening[k]);
            idle_cycles($urandom_range(0, 2));
        end
        last_page = opening[opening.size() - 1];

        // Random run over a drifting working set, with repeats and noise
        foreach (work_set[k]) work_set[k] = t_page'($urandom);
        sent = 0;
        while (sent < RANDOM_REFS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) work_set[$urandom_range(0, 5)] = t_page'($urandom);
            repeat (burst) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)      pg = work_set[$urandom_range(0, 5)];
                else if (pick < 8) pg = last_page;
                else               pg = t_page'($urandom);
                send_ref(pg);
                last_page = pg;
                sent++;
            end
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end

        // Build up counts on four resident frames, then force evictions among them
        foreach (hot_pages[k]) repeat (HAMMER_REFS) send_ref(hot_pages[k]);
        send_ref(8'h99);
        foreach (hot_pages[k]) send_ref(hot_pages[k]);
        send_ref(8'h99);
        idle_cycles(1);

        // Drain outstanding results, then allow the pipeline to settle
        waited = 0;
        while (pending_count != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[lfu_page_replacement.f]
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_page_replacement.sv
tb/lfu_page_checker.sv
tb/tb_lfu_page_replacement.sv
